>>> rtl/core/rrtt_pkg.sv
// Shared types, constants and helpers for the round-robin thread table.
`timescale 1ns / 1ps

package rrtt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TID_W  = 16;
  localparam int QNT_W  = 16;

  localparam logic [QNT_W-1:0] QUANTUM_RST = 16'd5;
  localparam logic [TID_W-1:0] FIRST_TID   = 16'd1;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_YIELD  = 3'd1;
  localparam logic [2:0] MODE_CREATE = 3'd2;
  localparam logic [2:0] MODE_EXIT   = 3'd3;
  localparam logic [2:0] MODE_JOIN   = 3'd4;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_RUNNABLE,
    ST_RUNNING,
    ST_SLEEPING
  } slot_st_e;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_NO_SLOT,
    STAT_BAD_TID,
    STAT_FINISHED,
    STAT_BLOCKED,
    STAT_NO_RUN,
    STAT_ALL_EXIT
  } status_e;

  typedef enum logic [1:0] {
    PASS_YIELD,
    PASS_CREATE,
    PASS_EXIT,
    PASS_JOIN
  } pass_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_TIDRD,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [TID_W-1:0]  wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } tid_req_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rrtt_tid_ram.sv
// Thread id store: one write port, one registered read port, unwritten slots read as zero.
`timescale 1ns / 1ps

module rrtt_tid_ram
  import rrtt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tid_req_t         req_i,
  output logic [TID_W-1:0] rdata_o
);

  logic [TID_W-1:0] tid_mem [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic [TID_W-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      tid_mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.raddr] ? tid_mem[req_i.raddr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rrtt_seq.sv
// Scheduler sequencer: slot states, slot scan unit, quantum and id counters, result register.
`timescale 1ns / 1ps

module rrtt_seq
  import rrtt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       mode_i,
  input  logic [TID_W-1:0] target_tid_i,
  input  logic             quantum_ticks_we_i,
  input  logic [QNT_W-1:0] quantum_ticks_i,
  output tid_req_t         tid_req_o,
  input  logic [TID_W-1:0] tid_rdata_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [TID_W-1:0] new_tid_o,
  output logic [3:0]       running_slot_o,
  output logic [TID_W-1:0] running_tid_o,
  output logic             switched_o,
  output logic             first_run_o
);

  seq_e              seq_q, seq_d;
  pass_e             pass_q, pass_d;
  slot_st_e          slot_state_q [SLOTS];
  slot_st_e          slot_state_d [SLOTS];
  logic [SLOTS-1:0]  started_q, started_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] iss_q, iss_d;
  logic [SLOT_W-1:0] ev_idx_q, ev_idx_d;
  logic              ev_valid_q, ev_valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TID_W-1:0]  next_id_q, next_id_d;
  logic [QNT_W-1:0]  qleft_q, qleft_d;
  logic [QNT_W-1:0]  qticks_q;
  logic              done_q, done_d;

  logic [TID_W-1:0]  target_q, target_d;
  logic              join_q, join_d;
  logic              was_run_q, was_run_d;
  logic              any_q, any_d;
  logic              alive_q, alive_d;
  logic              other_q, other_d;
  status_e           status_q, status_d;
  logic [TID_W-1:0]  created_q, created_d;
  logic              sw_q, sw_d;
  logic              first_q, first_d;

  status_e           out_status_q, out_status_d;
  logic [TID_W-1:0]  out_new_tid_q, out_new_tid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [TID_W-1:0]  out_rtid_q, out_rtid_d;
  logic              out_sw_q, out_sw_d;
  logic              out_first_q, out_first_d;

  slot_st_e          cur_st;
  slot_st_e          ev_st;
  logic              accept;
  logic              issue;
  logic              scan_end;
  logic              hit;
  logic              go_scan;
  logic              rescan;
  logic              yield_go;
  logic              yield_demote;
  logic              sw_now;
  logic [SLOT_W+3:0] slot_ext;

  assign busy     = (seq_q != SEQ_IDLE);
  assign accept   = start && !busy;
  assign cur_st   = slot_state_q[cur_q];
  assign ev_st    = slot_state_q[ev_idx_q];
  assign issue    = (cnt_q != CNT_W'(SLOTS));
  assign scan_end = !issue && !ev_valid_q;
  assign hit      = ev_valid_q &&
                    (((pass_q == PASS_YIELD) && (ev_st == ST_RUNNABLE)) ||
                     ((pass_q == PASS_CREATE) && (ev_st == ST_FREE)));
  assign sw_now   = !((ev_idx_q == cur_q) && was_run_q);

  always_comb begin
    go_scan = 1'b0;
    unique case (mode_i)
      MODE_TICK:   go_scan = (qleft_q <= QNT_W'(1));
      MODE_YIELD:  go_scan = 1'b1;
      MODE_CREATE: go_scan = (next_id_q != '0);
      MODE_EXIT:   go_scan = 1'b1;
      MODE_JOIN:   go_scan = !((next_id_q != '0) && (target_tid_i >= next_id_q));
      default:     go_scan = 1'b0;
    endcase
  end

  assign rescan = ((pass_q == PASS_EXIT) && any_q) ||
                  ((pass_q == PASS_JOIN) && alive_q && other_q);

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          seq_d = go_scan ? SEQ_SCAN : SEQ_TIDRD;
        end
      end
      SEQ_SCAN: begin
        if (hit) begin
          seq_d = SEQ_TIDRD;
        end else if (scan_end && !rescan) begin
          seq_d = SEQ_TIDRD;
        end
      end
      SEQ_TIDRD: seq_d = SEQ_DONE;
      SEQ_DONE:  seq_d = SEQ_IDLE;
      default:   seq_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    pass_d        = pass_q;
    slot_state_d  = slot_state_q;
    started_d     = started_q;
    cur_d         = cur_q;
    iss_d         = iss_q;
    ev_idx_d      = ev_idx_q;
    ev_valid_d    = ev_valid_q;
    cnt_d         = cnt_q;
    next_id_d     = next_id_q;
    qleft_d       = qleft_q;
    done_d        = 1'b0;
    target_d      = target_q;
    join_d        = join_q;
    was_run_d     = was_run_q;
    any_d         = any_q;
    alive_d       = alive_q;
    other_d       = other_q;
    status_d      = status_q;
    created_d     = created_q;
    sw_d          = sw_q;
    first_d       = first_q;
    out_status_d  = out_status_q;
    out_new_tid_d = out_new_tid_q;
    out_slot_d    = out_slot_q;
    out_rtid_d    = out_rtid_q;
    out_sw_d      = out_sw_q;
    out_first_d   = out_first_q;
    tid_req_o     = '0;
    yield_go      = 1'b0;
    yield_demote  = 1'b0;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          target_d   = target_tid_i;
          join_d     = 1'b0;
          was_run_d  = (cur_st == ST_RUNNING);
          any_d      = 1'b0;
          alive_d    = 1'b0;
          other_d    = 1'b0;
          status_d   = STAT_OK;
          created_d  = '0;
          sw_d       = 1'b0;
          first_d    = 1'b0;
          iss_d      = '0;
          cnt_d      = '0;
          ev_valid_d = 1'b0;
          unique case (mode_i)
            MODE_TICK: begin
              if (qleft_q <= QNT_W'(1)) begin
                yield_go     = 1'b1;
                yield_demote = 1'b1;
              end else begin
                qleft_d = qleft_q - QNT_W'(1);
              end
            end
            MODE_YIELD: begin
              yield_go     = 1'b1;
              yield_demote = 1'b1;
            end
            MODE_CREATE: begin
              qleft_d = qticks_q;
              pass_d  = PASS_CREATE;
              if (next_id_q == '0) begin
                status_d = STAT_NO_SLOT;
              end
            end
            MODE_EXIT: begin
              qleft_d             = qticks_q;
              slot_state_d[cur_q] = ST_FREE;
              pass_d              = PASS_EXIT;
            end
            MODE_JOIN: begin
              pass_d = PASS_JOIN;
              if ((next_id_q != '0) && (target_tid_i >= next_id_q)) begin
                status_d = STAT_BAD_TID;
              end
            end
            default: begin
              status_d = STAT_OK;
            end
          endcase
        end
      end

      SEQ_SCAN: begin
        if (issue) begin
          tid_req_o.re    = 1'b1;
          tid_req_o.raddr = iss_q;
          ev_valid_d      = 1'b1;
          ev_idx_d        = iss_q;
          iss_d           = slot_inc(iss_q);
          cnt_d           = cnt_q + CNT_W'(1);
        end else begin
          ev_valid_d = 1'b0;
        end

        if (ev_valid_q) begin
          unique case (pass_q)
            PASS_YIELD: begin
              if (ev_st == ST_RUNNABLE) begin
                slot_state_d[ev_idx_q] = ST_RUNNING;
                cur_d                  = ev_idx_q;
                sw_d                   = sw_now;
                first_d                = sw_now && !started_q[ev_idx_q];
                started_d[ev_idx_q]    = 1'b1;
                status_d               = join_q ? STAT_BLOCKED : STAT_OK;
              end
            end
            PASS_CREATE: begin
              if (ev_st == ST_FREE) begin
                slot_state_d[ev_idx_q] = ST_RUNNABLE;
                tid_req_o.we           = 1'b1;
                tid_req_o.waddr        = ev_idx_q;
                tid_req_o.wdata        = next_id_q;
                started_d[ev_idx_q]    = 1'b0;
                created_d              = next_id_q;
                next_id_d              = next_id_q + TID_W'(1);
                status_d               = STAT_OK;
              end
            end
            PASS_EXIT: begin
              if (ev_st == ST_SLEEPING) begin
                slot_state_d[ev_idx_q] = ST_RUNNABLE;
              end
              any_d = any_q || (ev_st != ST_FREE);
            end
            PASS_JOIN: begin
              alive_d = alive_q || ((ev_st != ST_FREE) && (tid_rdata_i == target_q));
              other_d = other_q || ((ev_idx_q != cur_q) && (ev_st == ST_RUNNABLE));
            end
            default: begin
              any_d = any_q;
            end
          endcase
        end

        if (scan_end) begin
          unique case (pass_q)
            PASS_YIELD:  status_d = STAT_NO_RUN;
            PASS_CREATE: status_d = STAT_NO_SLOT;
            PASS_EXIT: begin
              if (any_q) begin
                was_run_d = 1'b0;
                yield_go  = 1'b1;
              end else begin
                status_d = STAT_ALL_EXIT;
              end
            end
            PASS_JOIN: begin
              if (!alive_q) begin
                qleft_d  = qticks_q;
                status_d = STAT_FINISHED;
              end else if (!other_q) begin
                qleft_d  = qticks_q;
                status_d = STAT_NO_RUN;
              end else begin
                slot_state_d[cur_q] = ST_SLEEPING;
                join_d              = 1'b1;
                was_run_d           = 1'b0;
                yield_go            = 1'b1;
              end
            end
            default: status_d = status_q;
          endcase
        end
      end

      SEQ_TIDRD: begin
        tid_req_o.re    = 1'b1;
        tid_req_o.raddr = cur_q;
      end

      SEQ_DONE: begin
        done_d        = 1'b1;
        out_status_d  = status_q;
        out_new_tid_d = created_q;
        out_slot_d    = cur_q;
        out_rtid_d    = (cur_st == ST_RUNNING) ? tid_rdata_i : '0;
        out_sw_d      = sw_q;
        out_first_d   = first_q;
      end

      default: begin
        done_d = 1'b0;
      end
    endcase

    if (yield_go) begin
      qleft_d    = qticks_q;
      pass_d     = PASS_YIELD;
      iss_d      = slot_inc(cur_q);
      cnt_d      = '0;
      ev_valid_d = 1'b0;
      if (yield_demote && (cur_st == ST_RUNNING)) begin
        slot_state_d[cur_q] = ST_RUNNABLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= SEQ_IDLE;
      pass_q     <= PASS_YIELD;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state_q[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
      end
      started_q  <= SLOTS'(1);
      cur_q      <= '0;
      iss_q      <= '0;
      ev_idx_q   <= '0;
      ev_valid_q <= 1'b0;
      cnt_q      <= '0;
      next_id_q  <= FIRST_TID;
      qleft_q    <= QUANTUM_RST;
      qticks_q   <= QUANTUM_RST;
      done_q     <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      pass_q       <= pass_d;
      slot_state_q <= slot_state_d;
      started_q    <= started_d;
      cur_q        <= cur_d;
      iss_q        <= iss_d;
      ev_idx_q     <= ev_idx_d;
      ev_valid_q   <= ev_valid_d;
      cnt_q        <= cnt_d;
      next_id_q    <= next_id_d;
      qleft_q      <= qleft_d;
      done_q       <= done_d;
      if (quantum_ticks_we_i) begin
        qticks_q <= quantum_ticks_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q      <= target_d;
    join_q        <= join_d;
    was_run_q     <= was_run_d;
    any_q         <= any_d;
    alive_q       <= alive_d;
    other_q       <= other_d;
    status_q      <= status_d;
    created_q     <= created_d;
    sw_q          <= sw_d;
    first_q       <= first_d;
    out_status_q  <= out_status_d;
    out_new_tid_q <= out_new_tid_d;
    out_slot_q    <= out_slot_d;
    out_rtid_q    <= out_rtid_d;
    out_sw_q      <= out_sw_d;
    out_first_q   <= out_first_d;
  end

  assign slot_ext       = {4'b0000, out_slot_q};
  assign done_o         = done_q;
  assign status_o       = out_status_q;
  assign new_tid_o      = out_new_tid_q;
  assign running_slot_o = slot_ext[3:0];
  assign running_tid_o  = out_rtid_q;
  assign switched_o     = out_sw_q;
  assign first_run_o    = out_first_q;

endmodule

>>> rtl/core/round_robin_thread_table.sv
// Top level of the round-robin thread table: sequencer plus thread id store.
//
//   channel   signals                                   handshake
//   request   mode_i, target_tid_i                      taken when start && !busy
//   result    status_o, new_tid_o, running_slot_o,      one cycle, marked by done_o
//             running_tid_o, switched_o, first_run_o
//   config    quantum_ticks_i                           written when quantum_ticks_we_i
//
// A request that needs no slot scan (a tick that leaves quantum, a rejected join,
// a create with ids exhausted, an unused mode) goes from idle to the id read and the
// done state. A slot scan steps one slot per cycle through the id store read port;
// yield and create need one scan, exit and join up to two. busy stays high until
// the result cycle. Reset is asynchronous and needs no clearing pass. Results
// cannot be stalled.
`timescale 1ns / 1ps

module round_robin_thread_table
  import rrtt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       mode_i,
  input  logic [TID_W-1:0] target_tid_i,
  input  logic             quantum_ticks_we_i,
  input  logic [QNT_W-1:0] quantum_ticks_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [TID_W-1:0] new_tid_o,
  output logic [3:0]       running_slot_o,
  output logic [TID_W-1:0] running_tid_o,
  output logic             switched_o,
  output logic             first_run_o
);

  tid_req_t         tid_req;
  logic [TID_W-1:0] tid_rdata;

  rrtt_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .target_tid_i       (target_tid_i),
    .quantum_ticks_we_i (quantum_ticks_we_i),
    .quantum_ticks_i    (quantum_ticks_i),
    .tid_req_o          (tid_req),
    .tid_rdata_i        (tid_rdata),
    .done_o             (done_o),
    .status_o           (status_o),
    .new_tid_o          (new_tid_o),
    .running_slot_o     (running_slot_o),
    .running_tid_o      (running_tid_o),
    .switched_o         (switched_o),
    .first_run_o        (first_run_o)
  );

  rrtt_tid_ram u_tid_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tid_req),
    .rdata_o (tid_rdata)
  );

`ifndef SYNTHESIS
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_follows_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in flight");

  a_first_needs_switch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && first_run_o) |-> switched_o)
    else $error("first run flagged without a switch");

  a_switch_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && switched_o) |->
      ((status_o == STAT_OK) || (status_o == STAT_BLOCKED)))
    else $error("switch reported with a failing status");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking bench for the round-robin thread table: scheduling requests against a predictor.
`timescale 1ns / 1ps

module testbench;
  import rrtt_pkg::*;

  localparam int         STALL_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 2 * SLOTS + 6;
  localparam logic [2:0] MODE_SPARE   = 3'd5;

  typedef enum logic [1:0] {
    TGT_FIXED,
    TGT_LIVE,
    TGT_SELF
  } tgt_kind_e;

  typedef struct {
    bit               is_cfg;
    logic [QNT_W-1:0] cfg_val;
    logic [2:0]       mode;
    logic [TID_W-1:0] target;
    tgt_kind_e        kind;
    bit               may_gap;
  } sched_event_t;

  typedef struct {
    status_e           status;
    logic [TID_W-1:0]  new_tid;
    logic [SLOT_W-1:0] slot;
    logic [TID_W-1:0]  tid;
    bit                switched;
    bit                first_run;
  } sched_outcome_t;

  logic             clk_i;
  logic             rst_ni             = 1'b0;
  logic             start              = 1'b0;
  logic             busy;
  logic [2:0]       mode_r             = '0;
  logic [TID_W-1:0] target_r           = '0;
  logic             cfg_we             = 1'b0;
  logic [QNT_W-1:0] cfg_data           = '0;
  logic             done_o;
  logic [2:0]       status_o;
  logic [TID_W-1:0] new_tid_o;
  logic [3:0]       running_slot_o;
  logic [TID_W-1:0] running_tid_o;
  logic             switched_o;
  logic             first_run_o;

  slot_st_e          sched_state   [SLOTS];
  logic [TID_W-1:0]  sched_tid     [SLOTS];
  bit                sched_started [SLOTS];
  logic [SLOT_W-1:0] sched_cur;
  logic [TID_W-1:0]  sched_next_id;
  logic [QNT_W-1:0]  sched_qleft;
  logic [QNT_W-1:0]  sched_qticks;
  bit                pick_switched;
  bit                pick_first;

  sched_event_t   event_queue  [$];
  sched_outcome_t due_outcomes [$];

  int  events_issued = 0;
  int  events_taken  = 0;
  int  cfg_writes    = 0;
  int  checked       = 0;
  int  errors        = 0;
  int  stall_cycles  = 0;
  int  gap_left      = 0;
  int  status_hist   [7];
  bit  holding       = 1'b0;

  round_robin_thread_table dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_r),
    .target_tid_i       (target_r),
    .quantum_ticks_we_i (cfg_we),
    .quantum_ticks_i    (cfg_data),
    .done_o             (done_o),
    .status_o           (status_o),
    .new_tid_o          (new_tid_o),
    .running_slot_o     (running_slot_o),
    .running_tid_o      (running_tid_o),
    .switched_o         (switched_o),
    .first_run_o        (first_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic status_e run_next(input bit was_running);
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] idx;
    status_e           st;
    cur = sched_cur;
    st = STAT_NO_RUN;
    sched_qleft = sched_qticks;
    if (sched_state[cur] == ST_RUNNING) begin
      sched_state[cur] = ST_RUNNABLE;
    end
    for (int k = 1; k <= SLOTS; k++) begin
      idx = SLOT_W'((int'(cur) + k) % SLOTS);
      if (st == STAT_NO_RUN && sched_state[idx] == ST_RUNNABLE) begin
        sched_state[idx] = ST_RUNNING;
        sched_cur = idx;
        if (!(idx == cur && was_running)) begin
          pick_switched = 1'b1;
          if (!sched_started[idx]) begin
            pick_first = 1'b1;
          end
        end
        sched_started[idx] = 1'b1;
        st = STAT_OK;
      end
    end
    return st;
  endfunction

  function automatic sched_outcome_t schedule_event(input logic [2:0] mode,
                                                    input logic [TID_W-1:0] tgt);
    sched_outcome_t r;
    bit             was_running;
    bit             any_live;
    bit             alive;
    bit             other;
    r.status = STAT_OK;
    r.new_tid = '0;
    was_running = (sched_state[sched_cur] == ST_RUNNING);
    pick_switched = 1'b0;
    pick_first = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (sched_qleft <= 1) begin
          sched_qleft = '0;
          r.status = run_next(was_running);
        end else begin
          sched_qleft = sched_qleft - 1'b1;
        end
      end
      MODE_YIELD: begin
        r.status = run_next(was_running);
      end
      MODE_CREATE: begin
        sched_qleft = sched_qticks;
        r.status = STAT_NO_SLOT;
        if (sched_next_id != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (r.status == STAT_NO_SLOT && sched_state[i] == ST_FREE) begin
              sched_state[i] = ST_RUNNABLE;
              sched_tid[i] = sched_next_id;
              sched_started[i] = 1'b0;
              r.new_tid = sched_next_id;
              sched_next_id = sched_next_id + 1'b1;
              r.status = STAT_OK;
            end
          end
        end
      end
      MODE_EXIT: begin
        any_live = 1'b0;
        sched_qleft = sched_qticks;
        sched_state[sched_cur] = ST_FREE;
        for (int i = 0; i < SLOTS; i++) begin
          if (sched_state[i] == ST_SLEEPING) begin
            sched_state[i] = ST_RUNNABLE;
          end
          if (sched_state[i] != ST_FREE) begin
            any_live = 1'b1;
          end
        end
        if (any_live) begin
          r.status = run_next(1'b0);
        end else begin
          r.status = STAT_ALL_EXIT;
        end
      end
      MODE_JOIN: begin
        if (sched_next_id != 0 && tgt >= sched_next_id) begin
          r.status = STAT_BAD_TID;
        end else begin
          alive = 1'b0;
          other = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (sched_state[i] != ST_FREE && sched_tid[i] == tgt) begin
              alive = 1'b1;
            end
            if (SLOT_W'(i) != sched_cur && sched_state[i] == ST_RUNNABLE) begin
              other = 1'b1;
            end
          end
          if (!alive) begin
            sched_qleft = sched_qticks;
            r.status = STAT_FINISHED;
          end else if (!other) begin
            sched_qleft = sched_qticks;
            r.status = STAT_NO_RUN;
          end else begin
            sched_state[sched_cur] = ST_SLEEPING;
            void'(run_next(1'b0));
            r.status = STAT_BLOCKED;
          end
        end
      end
      default: begin
      end
    endcase
    r.slot = sched_cur;
    r.tid = (sched_state[sched_cur] == ST_RUNNING) ? sched_tid[sched_cur] : '0;
    r.switched = pick_switched;
    r.first_run = pick_first;
    return r;
  endfunction

  function automatic sched_event_t fixed_req(input logic [2:0] mode,
                                             input logic [TID_W-1:0] target,
                                             input tgt_kind_e kind, input bit gap);
    sched_event_t e;
    e.is_cfg = 1'b0;
    e.cfg_val = '0;
    e.mode = mode;
    e.target = target;
    e.kind = kind;
    e.may_gap = gap;
    return e;
  endfunction

  function automatic sched_event_t cfg_req(input logic [QNT_W-1:0] val);
    sched_event_t e;
    e = fixed_req(MODE_TICK, '0, TGT_FIXED, 1'b0);
    e.is_cfg = 1'b1;
    e.cfg_val = val;
    return e;
  endfunction

  function automatic sched_event_t rand_req(input int exit_bias, input bit gap);
    sched_event_t e;
    int           sel;
    int           tsel;
    sel = $urandom_range(0, 99);
    tsel = $urandom_range(0, 9);
    e = fixed_req(MODE_TICK, TID_W'($urandom), TGT_FIXED, gap);
    if (sel < 24) begin
      e.mode = MODE_TICK;
    end else if (sel < 38) begin
      e.mode = MODE_YIELD;
    end else if (sel < 58) begin
      e.mode = MODE_CREATE;
    end else if (sel < 70 + exit_bias) begin
      e.mode = MODE_EXIT;
    end else if (sel < 96) begin
      e.mode = MODE_JOIN;
      if (tsel < 6) begin
        e.kind = TGT_LIVE;
      end else if (tsel == 6) begin
        e.kind = TGT_SELF;
      end else if (tsel < 9) begin
        e.target = TID_W'($urandom_range(0, 40));
      end
    end else begin
      e.mode = MODE_SPARE + 3'($urandom_range(0, 2));
    end
    return e;
  endfunction

  task automatic wait_drained();
    while (event_queue.size() != 0 || holding || due_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin : driver
    sched_event_t     e;
    logic [TID_W-1:0] live [$];
    logic [TID_W-1:0] tgt;
    bit               n_start;
    bit               n_we;
    n_start = 1'b0;
    n_we = 1'b0;
    if (rst_ni) begin
      if (holding && events_taken == events_issued) begin
        holding = 1'b0;
      end
      if (holding) begin
        n_start = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (event_queue.size() != 0) begin
        e = event_queue[0];
        if (e.is_cfg) begin
          if (due_outcomes.size() == 0 && !busy) begin
            event_queue.delete(0);
            n_we = 1'b1;
            cfg_data <= e.cfg_val;
            cfg_writes++;
          end
        end else begin
          event_queue.delete(0);
          tgt = e.target;
          if (e.kind == TGT_SELF) begin
            tgt = sched_tid[sched_cur];
          end else if (e.kind == TGT_LIVE) begin
            live.delete();
            for (int i = 0; i < SLOTS; i++) begin
              if (sched_state[i] != ST_FREE) begin
                live.push_back(sched_tid[i]);
              end
            end
            if (live.size() != 0) begin
              tgt = live[$urandom_range(0, live.size() - 1)];
            end
          end
          mode_r <= e.mode;
          target_r <= tgt;
          n_start = 1'b1;
          holding = 1'b1;
          events_issued++;
          if (e.may_gap && $urandom_range(0, 2) == 0) begin
            gap_left = $urandom_range(1, 3);
          end
        end
      end
    end
    start <= n_start;
    cfg_we <= n_we;
  end

  always @(posedge clk_i) begin : monitor
    sched_outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (due_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got status %0d slot %0d tid %0h",
                   $time, status_o, running_slot_o, running_tid_o);
        end else begin
          want = due_outcomes.pop_front();
          checked++;
          status_hist[want.status]++;
          if (status_o !== want.status || new_tid_o !== want.new_tid ||
              running_slot_o !== 4'(want.slot) || running_tid_o !== want.tid ||
              switched_o !== want.switched || first_run_o !== want.first_run) begin
            errors++;
            $display({"%0t: mismatch: expected status %0d new_tid %0h slot %0d tid %0h",
                      " sw %0b first %0b, got status %0d new_tid %0h slot %0d tid %0h",
                      " sw %0b first %0b"}, $time,
                     want.status, want.new_tid, want.slot, want.tid, want.switched,
                     want.first_run, status_o, new_tid_o, running_slot_o,
                     running_tid_o, switched_o, first_run_o);
          end
        end
      end
      if (start && !busy) begin
        due_outcomes.push_back(schedule_event(mode_r, target_r));
        events_taken++;
      end
      if (cfg_we) begin
        sched_qticks = cfg_data;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || done_o || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < SLOTS; i++) begin
      sched_state[i] = ST_FREE;
      sched_tid[i] = '0;
      sched_started[i] = 1'b0;
    end
    for (int i = 0; i < 7; i++) begin
      status_hist[i] = 0;
    end
    sched_state[0] = ST_RUNNING;
    sched_started[0] = 1'b1;
    sched_cur = '0;
    sched_next_id = FIRST_TID;
    sched_qticks = QUANTUM_RST;
    sched_qleft = QUANTUM_RST;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // quantum runs out with a lone thread, then joins before any thread exists
    repeat (5) event_queue.push_back(fixed_req(MODE_TICK, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_YIELD, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, 16'hFFFF, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, 16'h0000, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_CREATE, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_CREATE, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, 16'h0001, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, '0, TGT_SELF, 1'b1));
    event_queue.push_back(fixed_req(MODE_YIELD, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_EXIT, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, 16'h0002, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, 16'h8000, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_SPARE, 16'hFFFF, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_SPARE + 3'd1, 16'h0000, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_SPARE + 3'd2, 16'hFFFF, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_CREATE, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_EXIT, '0, TGT_FIXED, 1'b1));
    event_queue.push_back(fixed_req(MODE_JOIN, '0, TGT_LIVE, 1'b1));

    event_queue.push_back(cfg_req(16'd1));
    repeat (200) event_queue.push_back(rand_req(0, 1'b1));
    event_queue.push_back(cfg_req(16'hFFFF));
    repeat (100) event_queue.push_back(rand_req(0, 1'b1));
    event_queue.push_back(cfg_req(16'd0));
    repeat (150) event_queue.push_back(rand_req(10, 1'b1));
    event_queue.push_back(cfg_req(16'd3));
    repeat (100) event_queue.push_back(rand_req(15, 1'b1));
    repeat (100) event_queue.push_back(rand_req(0, 1'b1));
    event_queue.push_back(cfg_req(16'd2));
    repeat (150) event_queue.push_back(rand_req(0, 1'b0));
    wait_drained();

    // empty the table and park on slot 0, then restart from an empty table
    repeat (SLOTS + 1) event_queue.push_back(fixed_req(MODE_EXIT, '0, TGT_FIXED, 1'b0));
    event_queue.push_back(fixed_req(MODE_CREATE, '0, TGT_FIXED, 1'b0));
    event_queue.push_back(fixed_req(MODE_YIELD, '0, TGT_FIXED, 1'b0));
    event_queue.push_back(fixed_req(MODE_EXIT, '0, TGT_FIXED, 1'b0));
    wait_drained();
    repeat (40) event_queue.push_back(rand_req(0, 1'b0));
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d scheduling requests under %0d quantum settings, %0d results checked.",
             events_taken, cfg_writes + 1, checked);
    $display({"Statuses ok/no_slot/bad_tid/finished/blocked/no_run/all_exit:",
              " %0d/%0d/%0d/%0d/%0d/%0d/%0d, id space exhausted: %0b"},
             status_hist[0], status_hist[1], status_hist[2], status_hist[3],
             status_hist[4], status_hist[5], status_hist[6], sched_next_id == 0);
    if (errors == 0 && due_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
